### rtl/tcw_pkg.sv
// shared constants, codes and item types for the text console writer
`default_nettype none
package tcw_pkg;

	localparam int unsigned COLS_DEFAULT = 80;
	localparam int unsigned ROWS_DEFAULT = 25;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ROW_W  = 5;
	localparam int unsigned COL_W  = 7;
	localparam int unsigned CELL_W = 16;

	localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'd15;

	typedef enum logic [MODE_W-1:0] {
		MODE_PRINT  = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_READ   = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] char_code;
		logic [BYTE_W-1:0] attr_in;
		logic [ROW_W-1:0]  cell_row;
		logic [COL_W-1:0]  cell_col;
	} in_item_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              scrolled;
		logic [BYTE_W-1:0] cell_char;
		logic [BYTE_W-1:0] cell_attr;
	} out_item_t;

endpackage
`default_nettype wire

### rtl/tcw_if.sv
// valid/ready channel interfaces for command and result items
`default_nettype none
interface tcw_in_if;
	logic               valid;
	logic               ready;
	tcw_pkg::in_item_t  item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface tcw_out_if;
	logic               valid;
	logic               ready;
	tcw_pkg::out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

### rtl/tcw_cell_ram.sv
// character/attribute cell store: one write port, one read port, registered read data
`default_nettype none
module tcw_cell_ram #(
	parameter int unsigned DEPTH = tcw_pkg::COLS_DEFAULT * tcw_pkg::ROWS_DEFAULT,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [tcw_pkg::CELL_W-1:0]  wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [tcw_pkg::CELL_W-1:0]  rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/tcw_ctrl.sv
// cursor state, command sequencer and cell store sweeps (clear, scroll, reset fill)
`default_nettype none
module tcw_ctrl #(
	parameter int unsigned COLS = tcw_pkg::COLS_DEFAULT,
	parameter int unsigned ROWS = tcw_pkg::ROWS_DEFAULT,
	parameter int unsigned AW   = $clog2(COLS * ROWS)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	output logic                             cmd_ready,
	input  wire tcw_pkg::in_item_t           cmd_item,
	input  wire logic [tcw_pkg::BYTE_W-1:0]  default_attr,
	output logic                             res_valid,
	output tcw_pkg::out_item_t               res_item,
	input  wire logic                        res_take,
	output logic                             ram_we,
	output logic [AW-1:0]                    ram_waddr,
	output logic [tcw_pkg::CELL_W-1:0]       ram_wdata,
	output logic                             ram_re,
	output logic [AW-1:0]                    ram_raddr,
	input  wire logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);

	localparam int unsigned N  = COLS * ROWS;
	localparam int unsigned CW = $clog2(COLS);
	localparam int unsigned RW = $clog2(ROWS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RDWAIT,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cur_x_q;
	logic [RW-1:0]       cur_y_q;
	logic [AW-1:0]       cnt_q;
	logic                copy_q;
	logic                init_q;
	tcw_pkg::out_item_t  res_q;

	logic                wv_s1;
	logic                wcopy_s1;
	logic [AW-1:0]       wa_s1;

	logic                accept;
	logic                is_nl;
	logic                last_col;
	logic                last_row;
	logic                adv_row;
	logic                do_scroll;
	logic [CW-1:0]       nx_x;
	logic [RW-1:0]       nx_y;
	logic [tcw_pkg::BYTE_W-1:0] attr_eff;
	logic [AW-1:0]       cur_addr;
	logic [AW-1:0]       rd_addr;
	logic                rd_in_range;
	logic                sweep_rd;
	tcw_pkg::out_item_t  res_nx;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = (state_q == ST_FINISH);
	assign res_item  = res_q;

	assign is_nl     = (cmd_item.char_code == tcw_pkg::NEWLINE_CODE);
	assign last_col  = (cur_x_q == CW'(COLS - 1));
	assign last_row  = (cur_y_q == RW'(ROWS - 1));
	assign adv_row   = is_nl || last_col;
	assign do_scroll = adv_row && last_row;
	assign nx_x      = adv_row ? '0 : cur_x_q + CW'(1);
	assign nx_y      = (adv_row && !last_row) ? cur_y_q + RW'(1) : cur_y_q;
	assign attr_eff  = (cmd_item.attr_in == '0) ? default_attr : cmd_item.attr_in;
	assign cur_addr  = AW'(int'(cur_y_q) * COLS + int'(cur_x_q));
	assign rd_addr   = AW'(int'(cmd_item.cell_row) * COLS + int'(cmd_item.cell_col));
	assign rd_in_range = (int'(cmd_item.cell_row) < ROWS) && (int'(cmd_item.cell_col) < COLS);
	assign sweep_rd  = (state_q == ST_SWEEP) && copy_q && (cnt_q < AW'(N - COLS));

	// result of the command being taken
	always_comb begin
		res_nx            = '0;
		res_nx.cursor_col = tcw_pkg::COL_W'(cur_x_q);
		res_nx.cursor_row = tcw_pkg::ROW_W'(cur_y_q);
		if (cmd_item.mode == tcw_pkg::MODE_PRINT) begin
			res_nx.cursor_col = tcw_pkg::COL_W'(nx_x);
			res_nx.cursor_row = tcw_pkg::ROW_W'(nx_y);
			res_nx.scrolled   = do_scroll;
		end
	end

	// memory port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_s1;
		ram_wdata = wcopy_s1 ? ram_rdata : '0;
		ram_re    = 1'b0;
		ram_raddr = AW'(int'(cnt_q) + COLS);
		if (wv_s1) begin
			ram_we = 1'b1;
		end else if (accept && cmd_item.mode == tcw_pkg::MODE_PRINT && !is_nl) begin
			ram_we    = 1'b1;
			ram_waddr = cur_addr;
			ram_wdata = {attr_eff, cmd_item.char_code};
		end
		if (sweep_rd) begin
			ram_re = 1'b1;
		end else if (accept && cmd_item.mode == tcw_pkg::MODE_READ && rd_in_range) begin
			ram_re    = 1'b1;
			ram_raddr = rd_addr;
		end
	end

	// sweep write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_s1    <= 1'b0;
			wcopy_s1 <= 1'b0;
			wa_s1    <= '0;
		end else begin
			wv_s1    <= (state_q == ST_SWEEP);
			wcopy_s1 <= sweep_rd;
			wa_s1    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			cur_x_q <= '0;
			cur_y_q <= '0;
			cnt_q   <= '0;
			copy_q  <= 1'b0;
			init_q  <= 1'b1;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= res_nx;
						cnt_q <= '0;
						case (cmd_item.mode)
							tcw_pkg::MODE_PRINT: begin
								cur_x_q <= nx_x;
								cur_y_q <= nx_y;
								copy_q <= 1'b1;
								state_q <= do_scroll ? ST_SWEEP : ST_FINISH;
							end
							tcw_pkg::MODE_CLEAR: begin
								copy_q  <= 1'b0;
								state_q <= ST_SWEEP;
							end
							tcw_pkg::MODE_READ: begin
								state_q <= rd_in_range ? ST_RDWAIT : ST_FINISH;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					if (cnt_q == AW'(N - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					init_q  <= 1'b0;
					state_q <= init_q ? ST_IDLE : ST_FINISH;
				end
				ST_RDWAIT: begin
					{res_q.cell_attr, res_q.cell_char} <= ram_rdata;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/text_console_writer.sv
// text console writer top level: config register, result register, sequencer and cell store
// A text-mode console over a ROWS x COLS store of 16-bit cells (character in the low byte,
// attribute in the high byte), held in one synchronous single-write, single-read memory.
// After reset the block fills the store with zero cells and takes no command item until
// that pass is done; default_attr may be written meanwhile. A print without scroll and
// mode 3 go straight to their result; an in-range read first waits for the registered
// read data of the memory. A clear or a print that scrolls walks the whole store through
// the memory's one read and one write port, one cell a cycle. Each command gives one
// result item, held in an output register so the next command can be taken while it waits.
`default_nettype none
module text_console_writer #(
	parameter int unsigned COLS = tcw_pkg::COLS_DEFAULT,
	parameter int unsigned ROWS = tcw_pkg::ROWS_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	tcw_in_if.sink                           cmd,
	tcw_out_if.source                        res,
	input  wire logic                        cfg_we,
	input  wire logic [tcw_pkg::BYTE_W-1:0]  cfg_wdata
);

	localparam int unsigned N  = COLS * ROWS;
	localparam int unsigned AW = $clog2(N);

	logic [tcw_pkg::BYTE_W-1:0] default_attr_q;
	logic                       out_valid_q;
	tcw_pkg::out_item_t         out_q;

	logic                       ctl_valid;
	tcw_pkg::out_item_t         ctl_item;
	logic                       ctl_take;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	assign ctl_take  = ctl_valid && (!out_valid_q || res.ready);
	assign res.valid = out_valid_q;
	assign res.item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= tcw_pkg::ATTR_RESET;
		end else if (cfg_we) begin
			default_attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (ctl_take) begin
			out_valid_q <= 1'b1;
			out_q       <= ctl_item;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	tcw_ctrl #(
		.COLS (COLS),
		.ROWS (ROWS),
		.AW   (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd.valid),
		.cmd_ready    (cmd.ready),
		.cmd_item     (cmd.item),
		.default_attr (default_attr_q),
		.res_valid    (ctl_valid),
		.res_item     (ctl_item),
		.res_take     (ctl_take),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	tcw_cell_ram #(
		.DEPTH (N),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
`default_nettype wire

### verif/console_checker.sv
// checker for the text console writer: screen and cursor predictor with result comparison
module console_checker
	import tcw_pkg::*;
#(
	parameter int unsigned COLS = COLS_DEFAULT,
	parameter int unsigned ROWS = ROWS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	tcw_in_if                 cmd,
	tcw_out_if                res,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata,
	output int                fail_count,
	output int                pending
);

	logic [CELL_W-1:0] cells [ROWS*COLS];
	int                cur_col;
	int                cur_row;
	logic [BYTE_W-1:0] dflt_attr;
	out_item_t         awaited [$];
	int                bad_count;
	int                results_seen;

	function automatic void blank_screen();
		foreach (cells[i])
			cells[i] = '0;
	endfunction

	function automatic out_item_t apply_command(input in_item_t c);
		out_item_t         r;
		logic [BYTE_W-1:0] a;
		r = '0;
		case (c.mode)
			MODE_PRINT: begin
				if (c.char_code == NEWLINE_CODE) begin
					cur_col = 0;
					cur_row++;
				end else begin
					a = (c.attr_in == 0) ? dflt_attr : c.attr_in;
					cells[cur_row*COLS + cur_col] = {a, c.char_code};
					cur_col++;
					if (cur_col >= COLS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= ROWS) begin
					// scroll up one row, blank the bottom row
					for (int i = 0; i < (ROWS-1)*COLS; i++)
						cells[i] = cells[i+COLS];
					for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++)
						cells[i] = '0;
					cur_row = ROWS - 1;
					cur_col = 0;
					r.scrolled = 1'b1;
				end
			end
			MODE_CLEAR: blank_screen();
			MODE_READ: begin
				if (c.cell_row < ROWS && c.cell_col < COLS)
					{r.cell_attr, r.cell_char} = cells[c.cell_row*COLS + c.cell_col];
			end
			default: ;
		endcase
		r.cursor_col = COL_W'(cur_col);
		r.cursor_row = ROW_W'(cur_row);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		out_item_t got;
		if (!arst_n) begin
			blank_screen();
			cur_col = 0;
			cur_row = 0;
			dflt_attr = ATTR_RESET;
			awaited.delete();
			bad_count = 0;
			results_seen = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				dflt_attr = cfg_wdata;
			if (res.valid && res.ready) begin
				got = res.item;
				if (awaited.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("result %0d arrived with none expected: %p", results_seen, got);
				end else begin
					exp_r = awaited.pop_front();
					if (got.cursor_col !== exp_r.cursor_col || got.cursor_row !== exp_r.cursor_row
							|| got.scrolled !== exp_r.scrolled
							|| got.cell_char !== exp_r.cell_char
							|| got.cell_attr !== exp_r.cell_attr) begin
						bad_count++;
						if (bad_count <= 10)
							$display("result %0d mismatch: expected %p, got %p",
								results_seen, exp_r, got);
					end
				end
				results_seen++;
			end
			if (cmd.valid && cmd.ready)
				awaited.push_back(apply_command(cmd.item));
			fail_count <= bad_count;
			pending <= awaited.size();
		end
	end

endmodule

### verif/tb_top.sv
// testbench top for the text console writer: clock, reset, command and config stimulus, verdict
module tb_top;
	import tcw_pkg::*;

	localparam int unsigned COLS = COLS_DEFAULT;
	localparam int unsigned ROWS = ROWS_DEFAULT;
	localparam int CMD_W = $bits(in_item_t);
	localparam longint unsigned LIMIT_CYCLES = 12_000_000;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 310;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;
	int                fail_count;
	int                pending;
	bit                calm;
	int                cmds_sent;

	tcw_in_if  cmd_ch ();
	tcw_out_if res_ch ();

	text_console_writer #(.COLS(COLS), .ROWS(ROWS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	console_checker #(.COLS(COLS), .ROWS(ROWS)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 8);
		$display("FAIL");
		$finish;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= calm || ($urandom_range(99) >= 18);
		end
	end

	function automatic in_item_t make_cmd(input mode_t m, input logic [BYTE_W-1:0] ch,
			input logic [BYTE_W-1:0] attr, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		in_item_t c;
		c.mode      = m;
		c.char_code = ch;
		c.attr_in   = attr;
		c.cell_row  = row;
		c.cell_col  = col;
		return c;
	endfunction

	task automatic send_command(input in_item_t c);
		while (!calm && $urandom_range(99) < 18) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.item  <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		cmds_sent++;
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_default_attr(input logic [BYTE_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic print_line();
		int r;
		int len;
		logic [BYTE_W-1:0] ch;
		r = $urandom_range(99);
		if (r < 60)
			len = $urandom_range(20);
		else if (r < 80)
			len = $urandom_range(78, 21);
		else if (r < 90)
			len = $urandom_range(COLS+1, COLS-1);
		else if (r < 97)
			len = $urandom_range(2*COLS+5, COLS+20);
		else
			len = 0;
		for (int i = 0; i < len; i++) begin
			ch = BYTE_W'($urandom_range(255));
			if (ch == NEWLINE_CODE)
				ch = ch + 8'd1;
			send_command(make_cmd(MODE_PRINT, ch,
				($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)),
				ROW_W'($urandom), COL_W'($urandom)));
		end
		if ($urandom_range(99) < 85)
			send_command(make_cmd(MODE_PRINT, NEWLINE_CODE, BYTE_W'($urandom),
				ROW_W'($urandom), COL_W'($urandom)));
	endtask

	task automatic read_cells();
		int n;
		n = $urandom_range(6, 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85)
				send_command(make_cmd(MODE_READ, BYTE_W'($urandom), BYTE_W'($urandom),
					ROW_W'($urandom_range(ROWS-1)), COL_W'($urandom_range(COLS-1))));
			else
				send_command(make_cmd(MODE_READ, BYTE_W'($urandom), BYTE_W'($urandom),
					ROW_W'($urandom_range(31)), COL_W'($urandom_range(127))));
		end
	endtask

	initial begin
		in_item_t raw;
		int r;
		logic [BYTE_W-1:0] phase_attr [PHASES];
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.item  = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		calm         = 1'b0;
		cmds_sent    = 0;
		phase_attr   = '{8'd0, 8'd255, 8'($urandom_range(255)), ATTR_RESET, 8'h80};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: blank read, zero char, default attr, extremes, unused mode, range edges
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd0, 7'd0));
		send_command(make_cmd(MODE_PRINT, 8'd0, 8'd0, 5'd0, 7'd0));
		send_command(make_cmd(MODE_PRINT, 8'd255, 8'd255, 5'd31, 7'd127));
		send_command(make_cmd(MODE_PRINT, 8'h41, 8'd1, 5'd0, 7'd0));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd0, 7'd0));
		send_command(make_cmd(MODE_READ, 8'd255, 8'd255, 5'd0, 7'd1));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd0, 7'd2));
		send_command(make_cmd(MODE_UNUSED, 8'd255, 8'd255, 5'd31, 7'd127));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'(ROWS), 7'd0));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd0, 7'(COLS)));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd31, 7'd127));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'(ROWS-1), 7'(COLS-1)));
		send_command(make_cmd(MODE_PRINT, NEWLINE_CODE, 8'd255, 5'd0, 7'd0));
		send_command(make_cmd(MODE_PRINT, 8'h7e, 8'd0, 5'd0, 7'd0));
		send_command(make_cmd(MODE_CLEAR, 8'd255, 8'd255, 5'd31, 7'd127));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd1, 7'd0));
		drain_results();
		set_default_attr(8'd0);
		send_command(make_cmd(MODE_PRINT, 8'h78, 8'd0, 5'd0, 7'd0));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd1, 7'd1));
		drain_results();
		set_default_attr(8'd255);
		send_command(make_cmd(MODE_PRINT, 8'h79, 8'd0, 5'd0, 7'd0));
		send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 5'd1, 7'd2));

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			set_default_attr(phase_attr[p]);
			calm = (p == 2);
			r = cmds_sent + PHASE_ITEMS;
			while (cmds_sent < r) begin
				case ($urandom_range(99)) inside
					[0:59]:  print_line();
					[60:84]: read_cells();
					[85:89]: begin
						raw = CMD_W'($urandom);
						send_command(raw);
					end
					[90:92]: send_command(make_cmd(MODE_CLEAR, BYTE_W'($urandom),
						BYTE_W'($urandom), ROW_W'($urandom), COL_W'($urandom)));
					default: send_command(make_cmd(MODE_UNUSED, BYTE_W'($urandom),
						BYTE_W'($urandom), ROW_W'($urandom), COL_W'($urandom)));
				endcase
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_cell_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
verif/console_checker.sv
verif/tb_top.sv
